// ===== rtl/load_cell_adc_reader_top_assert.svh =====
// assertion macros for the load cell reader
`ifndef LOAD_CELL_ADC_READER_TOP_ASSERT_SVH
`define LOAD_CELL_ADC_READER_TOP_ASSERT_SVH

// same-cycle implication
`define LCAR_ASSERT_HOLDS(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("load cell reader check failed");

// next-cycle implication
`define LCAR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("load cell reader check failed");

`endif

// ===== rtl/lcar_pkg.sv =====
`default_nettype none
package lcar_pkg;

  localparam int DATA_BITS_DEF    = 24;
  localparam int EXTRA_PULSES_DEF = 3;

  localparam int SUM_W = 32;
  localparam int CNT_W = 8;

  localparam logic [SUM_W-1:0] OFFSET_RESET = 32'd2200000;
  localparam logic [CNT_W-1:0] HALF_RESET   = 8'd1;
  localparam logic [5:0]       DIV_STEPS    = 6'd32;

  localparam logic [2:0] KIND_MEASURE  = 3'd1;
  localparam logic [2:0] KIND_TARE     = 3'd2;
  localparam logic [2:0] KIND_LOAD_OFS = 3'd3;
  localparam logic [2:0] KIND_PWR_DOWN = 3'd4;
  localparam logic [2:0] KIND_PWR_UP   = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_DIVIDE = 3'd4
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/load_cell_adc_reader_top.sv =====
// load cell converter reader
// input channel (in_valid/in_ready): one beat is one timing tick carrying the
// sampled DT level and a command kind (measure, tare, load offset, power
// down, power up) with its sample count or offset value.
// output channel (out_valid/out_ready): exactly one beat per input beat, with
// the SCK level to drive, busy flag, finished result and current offset.
// config channel (cfg_valid/cfg_ready/cfg_data): sck half period in ticks,
// always ready; write it only while idle.
// the result beat of a tick is registered and appears in the cycle after the
// tick is taken. throughput: one tick per cycle while no result beat is held;
// the tick state machine, its single 32-bit adder and 9-bit divide step are combinational.
// a conversion takes the wait for DT low plus 27 pulses of two half periods;
// the average is formed by a restoring divider, one quotient bit per tick,
// 32 ticks. measure or tare with a zero count finishes on its own tick.
// reset: idle, powered up, offset 2200000, half period 1, no beat pending.
// stall: a held result beat keeps in_ready low, so ticks are not lost and
// the converter timing simply pauses.
`default_nettype none
module load_cell_adc_reader_top #(
  parameter int DATA_BITS    = lcar_pkg::DATA_BITS_DEF,
  parameter int EXTRA_PULSES = lcar_pkg::EXTRA_PULSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic        dt_level,
  input  logic [7:0]  sample_count,
  input  logic signed [31:0] offset_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sck_level,
  output logic        busy_res,
  output logic        result_valid,
  output logic        result_is_tare,
  output logic signed [31:0] weight_value,
  output logic signed [31:0] offset_now
);
  import lcar_pkg::*;

  localparam logic [4:0] DATA_IDX    = 5'(DATA_BITS);
  localparam logic [4:0] PULSE_TOTAL = 5'(DATA_BITS + EXTRA_PULSES);

  logic [CNT_W-1:0]     sck_half_ticks;
  phase_t               phase, phase_next;
  logic [SUM_W-1:0]     zero_offset, zero_offset_next;
  logic [DATA_BITS-1:0] shift_word, shift_word_next;
  logic [SUM_W-1:0]     running_sum, running_sum_next;
  logic [CNT_W-1:0]     samples_left, samples_left_next;
  logic [CNT_W-1:0]     samples_total, samples_total_next;
  logic [4:0]           pulse_index, pulse_index_next;
  logic [CNT_W-1:0]     half_tick_count, half_tick_count_next;
  logic [5:0]           divide_step, divide_step_next;
  logic [SUM_W-1:0]     quotient_work, quotient_work_next;
  logic [CNT_W-1:0]     remainder_work, remainder_work_next;
  logic                 powered_down, powered_down_next;
  logic                 doing_tare, doing_tare_next;

  logic                 finish;
  logic                 in_fire;

  // divide step
  logic [CNT_W:0]       rem_shift;
  logic [CNT_W:0]       rem_diff;
  logic                 rem_fits;
  logic [CNT_W-1:0]     rem_step;
  logic [SUM_W-1:0]     quo_step;
  logic [5:0]           step_inc;
  logic [4:0]           pulse_inc;
  logic [SUM_W-1:0]     avg_value;

  // shared adder
  logic [SUM_W-1:0]     add_a, add_b, add_sum;
  logic                 add_cin;

  logic                 sck_d, busy_d, rv_d, tare_d;
  logic [SUM_W-1:0]     weight_d;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign rem_shift = {remainder_work, quotient_work[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, samples_total};
  assign rem_fits  = (samples_total != '0) && (rem_shift >= {1'b0, samples_total});
  assign rem_step  = rem_fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
  assign quo_step  = {quotient_work[SUM_W-2:0], rem_fits};
  assign step_inc  = divide_step + 6'd1;
  assign pulse_inc = pulse_index + 5'd1;
  assign avg_value = (phase == PH_DIVIDE) ? quo_step : '0;

  // accumulate in the pulse phase, otherwise average minus offset
  assign add_a   = (phase == PH_LOW) ? running_sum : avg_value;
  assign add_b   = (phase == PH_LOW) ? {{(SUM_W-DATA_BITS){1'b0}}, shift_word} : ~zero_offset;
  assign add_cin = (phase != PH_LOW);
  assign add_sum = add_a + add_b + {{(SUM_W-1){1'b0}}, add_cin};

  always_comb begin
    phase_next           = phase;
    zero_offset_next     = zero_offset;
    shift_word_next      = shift_word;
    running_sum_next     = running_sum;
    samples_left_next    = samples_left;
    samples_total_next   = samples_total;
    pulse_index_next     = pulse_index;
    half_tick_count_next = half_tick_count;
    divide_step_next     = divide_step;
    quotient_work_next   = quotient_work;
    remainder_work_next  = remainder_work;
    powered_down_next    = powered_down;
    doing_tare_next      = doing_tare;
    finish               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if ((kind == KIND_MEASURE || kind == KIND_TARE) && !powered_down) begin
          doing_tare_next = (kind == KIND_TARE);
          if (sample_count == '0) begin
            finish = 1'b1;
          end else begin
            samples_total_next = sample_count;
            samples_left_next  = sample_count;
            running_sum_next   = '0;
            phase_next         = PH_WAIT;
          end
        end else if (kind == KIND_LOAD_OFS) begin
          zero_offset_next = offset_value;
        end else if (kind == KIND_PWR_DOWN) begin
          powered_down_next = 1'b1;
        end else if (kind == KIND_PWR_UP) begin
          powered_down_next = 1'b0;
        end
      end
      PH_WAIT: begin
        if (!dt_level) begin
          shift_word_next      = '0;
          pulse_index_next     = '0;
          half_tick_count_next = 8'd1;
          phase_next           = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (half_tick_count >= sck_half_ticks) begin
          if (pulse_index < DATA_IDX) begin
            shift_word_next = {shift_word[DATA_BITS-2:0], dt_level};
          end
          half_tick_count_next = 8'd1;
          phase_next           = PH_LOW;
        end else begin
          half_tick_count_next = half_tick_count + 8'd1;
        end
      end
      PH_LOW: begin
        if (half_tick_count >= sck_half_ticks) begin
          pulse_index_next = pulse_inc;
          if (pulse_inc >= PULSE_TOTAL) begin
            running_sum_next  = add_sum;
            samples_left_next = samples_left - 8'd1;
            if (samples_left == 8'd1) begin
              quotient_work_next  = add_sum;
              remainder_work_next = '0;
              divide_step_next    = '0;
              phase_next          = PH_DIVIDE;
            end else begin
              phase_next = PH_WAIT;
            end
          end else begin
            half_tick_count_next = 8'd1;
            phase_next           = PH_HIGH;
          end
        end else begin
          half_tick_count_next = half_tick_count + 8'd1;
        end
      end
      PH_DIVIDE: begin
        remainder_work_next = rem_step;
        quotient_work_next  = quo_step;
        divide_step_next    = step_inc;
        if (step_inc >= DIV_STEPS) begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (finish) begin
      phase_next = PH_IDLE;
      if (doing_tare_next) begin
        zero_offset_next = avg_value;
      end
    end
  end

  always_comb begin
    busy_d   = (phase_next != PH_IDLE);
    sck_d    = 1'b0;
    if (phase_next == PH_HIGH) begin
      sck_d = 1'b1;
    end else if (phase_next == PH_IDLE) begin
      sck_d = powered_down_next;
    end
    rv_d     = finish;
    tare_d   = finish && doing_tare_next;
    weight_d = '0;
    if (finish) begin
      weight_d = doing_tare_next ? avg_value : add_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sck_half_ticks <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sck_half_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      zero_offset     <= OFFSET_RESET;
      shift_word      <= '0;
      running_sum     <= '0;
      samples_left    <= '0;
      samples_total   <= '0;
      pulse_index     <= '0;
      half_tick_count <= '0;
      divide_step     <= '0;
      quotient_work   <= '0;
      remainder_work  <= '0;
      powered_down    <= 1'b0;
      doing_tare      <= 1'b0;
    end else if (in_fire) begin
      phase           <= phase_next;
      zero_offset     <= zero_offset_next;
      shift_word      <= shift_word_next;
      running_sum     <= running_sum_next;
      samples_left    <= samples_left_next;
      samples_total   <= samples_total_next;
      pulse_index     <= pulse_index_next;
      half_tick_count <= half_tick_count_next;
      divide_step     <= divide_step_next;
      quotient_work   <= quotient_work_next;
      remainder_work  <= remainder_work_next;
      powered_down    <= powered_down_next;
      doing_tare      <= doing_tare_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sck_level      <= sck_d;
      busy_res       <= busy_d;
      result_valid   <= rv_d;
      result_is_tare <= tare_d;
      weight_value   <= weight_d;
      offset_now     <= zero_offset_next;
    end
  end

`include "load_cell_adc_reader_top_assert.svh"

  `LCAR_ASSERT_HOLDS(a_rem_bound, clk, rst, phase == PH_DIVIDE, remainder_work < samples_total)
  `LCAR_ASSERT_HOLDS(a_pulse_range, clk, rst, phase == PH_HIGH, pulse_index < PULSE_TOTAL)
  `LCAR_ASSERT_HOLDS(a_done_idle, clk, rst, out_valid && result_valid, !busy_res)
  `LCAR_ASSERT_NEXT(a_sum_start, clk, rst, in_fire && phase == PH_IDLE && !powered_down && (kind == KIND_MEASURE || kind == KIND_TARE) && sample_count != 8'd0, phase == PH_WAIT && running_sum == '0)

endmodule
`default_nettype wire

// ===== dv/load_cell_adc_reader_top_tb.sv =====
`timescale 1ns / 1ps
module load_cell_adc_reader_top_tb;
  import lcar_pkg::*;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int PULSES      = DATA_BITS_DEF + EXTRA_PULSES_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {DT_RANDOM, DT_ONES, DT_ZEROS} dt_fill_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        dt;
    logic [7:0]  count;
    logic [31:0] ofs;
  } tick_t;

  typedef struct packed {
    logic        sck;
    logic        busy;
    logic        done;
    logic        is_tare;
    logic [31:0] weight;
    logic [31:0] offset;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = 3'd0;
  logic dt_level = 1'b0;
  logic [7:0] sample_count = 8'd0;
  logic signed [31:0] offset_value = 32'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic sck_level;
  logic busy_res;
  logic result_valid;
  logic result_is_tare;
  logic signed [31:0] weight_value;
  logic signed [31:0] offset_now;

  tick_t    tick_queue[$];
  reading_t due_readings[$];
  int errors = 0;
  int sent_ticks = 0;
  int finished_ops = 0;
  int idle_cycles = 0;
  int cycle_no = 0;
  logic steady;

  // reader state as predicted
  logic [7:0]  half_cfg = HALF_RESET;
  phase_t      ph = PH_IDLE;
  logic [31:0] zero_ofs = OFFSET_RESET;
  logic [DATA_BITS_DEF-1:0] shreg = '0;
  logic [31:0] acc = '0;
  logic [7:0]  left_n = '0;
  logic [7:0]  total_n = '0;
  logic [4:0]  pulse_no = '0;
  logic [7:0]  half_cnt = '0;
  logic [5:0]  div_no = '0;
  logic [31:0] quo = '0;
  logic [31:0] rem = '0;
  logic        pwr_down = 1'b0;
  logic        tare_op = 1'b0;

  load_cell_adc_reader_top DUT (.*);

  always #4 clk = ~clk;

  assign steady = (cycle_no % 2000) >= 1400;

  task automatic step_reader(input tick_t t);
    reading_t r;
    logic fin;
    logic [31:0] avg;
    r = '0;
    fin = 1'b0;
    avg = '0;
    case (ph)
      PH_IDLE: begin
        if ((t.kind == KIND_MEASURE || t.kind == KIND_TARE) && !pwr_down) begin
          tare_op = (t.kind == KIND_TARE);
          if (t.count == 8'd0) begin
            fin = 1'b1;
          end else begin
            total_n = t.count;
            left_n = t.count;
            acc = '0;
            ph = PH_WAIT;
          end
        end else if (t.kind == KIND_LOAD_OFS) begin
          zero_ofs = t.ofs;
        end else if (t.kind == KIND_PWR_DOWN) begin
          pwr_down = 1'b1;
        end else if (t.kind == KIND_PWR_UP) begin
          pwr_down = 1'b0;
        end
      end
      PH_WAIT: begin
        if (!t.dt) begin
          shreg = '0;
          pulse_no = '0;
          half_cnt = 8'd1;
          ph = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (half_cnt >= half_cfg) begin
          if (pulse_no < DATA_BITS_DEF) shreg = {shreg[DATA_BITS_DEF-2:0], t.dt};
          half_cnt = 8'd1;
          ph = PH_LOW;
        end else begin
          half_cnt = half_cnt + 8'd1;
        end
      end
      PH_LOW: begin
        if (half_cnt >= half_cfg) begin
          pulse_no = pulse_no + 5'd1;
          if (pulse_no >= PULSES) begin
            acc = acc + {{(32-DATA_BITS_DEF){1'b0}}, shreg};
            left_n = left_n - 8'd1;
            if (left_n == 8'd0) begin
              quo = acc;
              rem = '0;
              div_no = '0;
              ph = PH_DIVIDE;
            end else begin
              ph = PH_WAIT;
            end
          end else begin
            half_cnt = 8'd1;
            ph = PH_HIGH;
          end
        end else begin
          half_cnt = half_cnt + 8'd1;
        end
      end
      PH_DIVIDE: begin
        rem = {rem[30:0], quo[31]};
        quo = {quo[30:0], 1'b0};
        if (total_n != 8'd0 && rem >= {24'd0, total_n}) begin
          rem = rem - {24'd0, total_n};
          quo[0] = 1'b1;
        end
        div_no = div_no + 6'd1;
        if (div_no >= DIV_STEPS) begin
          fin = 1'b1;
          avg = quo;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (fin) begin
      r.done = 1'b1;
      r.is_tare = tare_op;
      if (tare_op) begin
        zero_ofs = avg;
        r.weight = avg;
      end else begin
        r.weight = avg - zero_ofs;
      end
      ph = PH_IDLE;
    end
    r.sck = (ph == PH_HIGH) || (ph == PH_IDLE && pwr_down);
    r.busy = (ph != PH_IDLE);
    r.offset = zero_ofs;
    due_readings.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) step_reader({kind, dt_level, sample_count, offset_value});
      if (!in_valid || in_ready) begin
        if (tick_queue.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
          t = tick_queue.pop_front();
          kind <= t.kind;
          dt_level <= t.dt;
          sample_count <= t.count;
          offset_value <= t.ofs;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_readings.size() == 0) begin
          errors++;
          $display("%0t: beat expected none got weight %0h offset %0h", $time,
                   weight_value, offset_now);
        end else begin
          want = due_readings.pop_front();
          check_field("sck_level", want.sck, sck_level);
          check_field("busy_res", want.busy, busy_res);
          check_field("result_valid", want.done, result_valid);
          check_field("result_is_tare", want.is_tare, result_is_tare);
          check_field("weight_value", want.weight, weight_value);
          check_field("offset_now", want.offset, offset_now);
          if (result_valid) finished_ops++;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic put_tick(input logic [2:0] k, input logic d, input logic [7:0] c,
                          input logic [31:0] o);
    while (tick_queue.size() >= 8) @(posedge clk);
    tick_queue.push_back({k, d, c, o});
    sent_ticks++;
  endtask

  task automatic settle();
    do begin
      while (tick_queue.size() != 0 || in_valid || due_readings.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
      if (ph != PH_IDLE) begin
        repeat (8) put_tick(KIND_TICK, 1'($urandom_range(1)), 8'($urandom), $urandom);
      end
    end while (ph != PH_IDLE || tick_queue.size() != 0 || in_valid ||
               due_readings.size() != 0);
  endtask

  task automatic write_half(input logic [7:0] v);
    settle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_cfg = v;
  endtask

  // command beat, then the dt pattern of each conversion and the divide, cut short if broken
  task automatic run_op(input logic [2:0] k, input logic [7:0] cnt, input dt_fill_t fill,
                        input bit noisy, input bit broken);
    bit dt_plan[$];
    int h;
    int stop_at;
    h = (half_cfg == 8'd0) ? 1 : int'(half_cfg);
    put_tick(k, 1'($urandom_range(1)), cnt, $urandom);
    repeat (cnt) begin
      repeat ($urandom_range(3)) dt_plan.push_back(1'b1);
      dt_plan.push_back(1'b0);
      repeat (2 * PULSES * h)
        dt_plan.push_back(fill == DT_ONES || (fill == DT_RANDOM && $urandom_range(1) == 1));
    end
    if (cnt != 8'd0) repeat (DIV_STEPS) dt_plan.push_back(1'($urandom_range(1)));
    stop_at = broken ? $urandom_range(dt_plan.size()) : dt_plan.size();
    for (int i = 0; i < stop_at; i++)
      put_tick((noisy && $urandom_range(99) < 4) ? 3'($urandom_range(7)) : KIND_TICK,
               dt_plan[i], 8'($urandom), $urandom);
  endtask

  task automatic random_phase(input int n, input int d);
    int first_tick;
    int goal;
    int r;
    logic [7:0] cnt;
    logic [31:0] ofs;
    dt_fill_t fill;
    first_tick = sent_ticks;
    goal = finished_ops + d;
    while ((sent_ticks - first_tick < n || finished_ops < goal) &&
           sent_ticks - first_tick < 1000) begin
      r = $urandom_range(99);
      if (r < 60) begin
        r = $urandom_range(99);
        cnt = (r < 10) ? 8'd0 : (r < 85) ? 8'($urandom_range(3, 1)) : 8'($urandom_range(8, 4));
        fill = ($urandom_range(9) == 0) ? DT_ONES :
               ($urandom_range(9) == 0) ? DT_ZEROS : DT_RANDOM;
        run_op(($urandom_range(9) < 7) ? KIND_MEASURE : KIND_TARE, cnt, fill, 1'b1,
               $urandom_range(9) == 0);
      end else if (r < 70) begin
        case ($urandom_range(7))
          0: ofs = 32'h8000_0000;
          1: ofs = 32'h7fff_ffff;
          2: ofs = 32'hffff_ffff;
          3: ofs = 32'h0;
          default: ofs = $urandom;
        endcase
        put_tick(KIND_LOAD_OFS, 1'($urandom_range(1)), 8'($urandom), ofs);
      end else if (r < 74) begin
        put_tick(KIND_PWR_DOWN, 1'($urandom_range(1)), 8'($urandom), $urandom);
      end else if (r < 84) begin
        put_tick(KIND_PWR_UP, 1'($urandom_range(1)), 8'($urandom), $urandom);
      end else if (r < 95) begin
        put_tick(KIND_TICK, 1'($urandom_range(1)), 8'($urandom), $urandom);
      end else begin
        put_tick($urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B, 1'($urandom_range(1)),
                 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_half(8'd1);

    put_tick(KIND_TICK, 1'b1, 8'hff, 32'hffff_ffff);
    put_tick(KIND_PWR_DOWN, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_MEASURE, 1'b0, 8'd3, 32'h0);
    put_tick(KIND_TARE, 1'b0, 8'd2, 32'h0);
    put_tick(KIND_LOAD_OFS, 1'b1, 8'd0, 32'h7fff_ffff);
    put_tick(KIND_PWR_UP, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_LOAD_OFS, 1'b0, 8'd0, 32'h8000_0000);
    put_tick(KIND_MEASURE, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_TARE, 1'b1, 8'd0, 32'h5555_5555);
    put_tick(KIND_SPARE_A, 1'b0, 8'd1, 32'h7);
    put_tick(KIND_SPARE_B, 1'b1, 8'd2, 32'h9);
    put_tick(KIND_LOAD_OFS, 1'b0, 8'd0, 32'hffff_ffff);
    run_op(KIND_MEASURE, 8'd1, DT_ONES, 1'b0, 1'b0);
    run_op(KIND_TARE, 8'd2, DT_ZEROS, 1'b0, 1'b0);
    run_op(KIND_MEASURE, 8'd3, DT_RANDOM, 1'b1, 1'b0);

    write_half(8'd255);
    put_tick(KIND_MEASURE, 1'b1, 8'd0, 32'h0);
    put_tick(KIND_PWR_DOWN, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_TICK, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_PWR_UP, 1'b1, 8'd0, 32'h0);
    put_tick(KIND_TARE, 1'b0, 8'd0, 32'h0);
    put_tick(KIND_LOAD_OFS, 1'b0, 8'd0, 32'h0012_3456);
    write_half(8'd1);
    run_op(KIND_TARE, 8'd4, DT_ONES, 1'b0, 1'b0);

    write_half(8'd0);
    random_phase(150, 2);
    write_half(8'd2);
    random_phase(150, 1);
    write_half(8'd1);
    random_phase(150, 2);

    settle();
    repeat (5) @(posedge clk);
    if (errors == 0 && due_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
